>>> rtl/brf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_pkg: shared types and constants of the bracketing root finder
// Fixed-point format, register indexes, status codes, FSM states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package brf_pkg;

	localparam int FRAC_BITS = 16;

	// reset tolerance: 0.001 rounded to Q format
	localparam logic [30:0] TOL_RESET = 31'(((1 << FRAC_BITS) + 500) / 1000);
	localparam logic [15:0] CAP_RESET = 16'd64;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_METHOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOL    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CAP    = 2'd2;

	// request types
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_VALUE = 1'b1;

	// probe forming methods
	localparam logic METH_BISECT = 1'b0;
	localparam logic METH_FALSEPOS = 1'b1;

	// divider: one quotient bit per cycle
	localparam int DIV_STEPS = 64;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	typedef enum logic [2:0] {
		STAT_PROBE    = 3'd0,
		STAT_CONV     = 3'd1,
		STAT_NOSIGN   = 3'd2,
		STAT_DENZERO  = 3'd3,
		STAT_CAP      = 3'd4,
		STAT_IGNORED  = 3'd5
	} status_t;

	// source of the result point
	typedef enum logic [1:0] {
		PSEL_ZERO,
		PSEL_CUR,
		PSEL_MID,
		PSEL_FP
	} psel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_CHECK,
		S_PROBE,
		S_MUL,
		S_DIV,
		S_CLAMP,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic    start_load;   // take endpoints and values of a start word
		logic    value_update; // narrow bracket with probe_value
		logic    mul_load;     // register secant numerator/denominator
		logic    div_start;
		logic    clamp_load;   // register clamped false-position point
		logic    out_load;     // load result word into output register
		status_t status;
		psel_t   psel;
	} cmd_t;

	typedef struct packed {
		logic sign_change;
		logic den_zero;
		logic width_ok;
		logic cap_hit;
		logic div_done;
		logic out_free;
	} dp_stat_t;

endpackage

>>> rtl/brf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_div: unsigned restoring divider
// 64-bit dividend by 33-bit divisor, one quotient bit per cycle.
// done is high for a single cycle, registered along with the last step; quo holds until next start.
// ----------------------------------------------------------------------------
module brf_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [32:0] den,
	output logic        done,
	output logic [63:0] quo
);

	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [32:0] den_q;
	logic [brf_pkg::DIV_CNT_W-1:0] cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [33:0] shifted;
	logic [34:0] trial;
	logic        ge;

	assign shifted = {rem_q, quo_q[63]};
	assign trial   = {1'b0, shifted} - {2'b00, den_q};
	assign ge      = ~trial[34];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= brf_pkg::DIV_CNT_W'(brf_pkg::DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == brf_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? trial[32:0] : shifted[32:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

>>> rtl/brf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_dp: root finder datapath
// Bracket registers, width and cap tests, midpoint, secant product,
// divider, clamp and the output register.
// ----------------------------------------------------------------------------
module brf_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  brf_pkg::cmd_t       cmd,
	output brf_pkg::dp_stat_t   stat,
	input  logic signed [31:0]  left_end,
	input  logic signed [31:0]  right_end,
	input  logic signed [31:0]  left_value,
	input  logic signed [31:0]  right_value,
	input  logic signed [31:0]  probe_value,
	input  logic [30:0]         width_tolerance,
	input  logic [15:0]         iteration_cap,
	input  logic                out_stall,
	output logic                out_valid,
	output logic signed [31:0]  probe_point,
	output logic [2:0]          status,
	output logic [15:0]         probe_count
);

	// search state
	logic signed [31:0] bl_q, br_q, vl_q, vr_q, cp_q;
	logic [15:0]        pd_q;

	// secant path
	logic [63:0]        num_q;
	logic [32:0]        dmag_q;
	logic               neg_q;
	logic signed [31:0] fp_q;

	// output word
	logic               ov_q;
	logic signed [31:0] op_q;
	logic [2:0]         os_q;
	logic [15:0]        oc_q;

	logic signed [32:0] diff;
	logic [31:0]        wmag;
	logic signed [32:0] sum;
	logic signed [31:0] mid;
	logic signed [32:0] den;
	logic [31:0]        flmag;
	logic [63:0]        quo;
	logic               div_done;
	logic signed [65:0] q_ext;
	logic signed [65:0] x_raw;
	logic signed [31:0] lo, hi;
	logic signed [31:0] x_clamp;
	logic signed [31:0] pt;
	logic               move_right;

	assign diff  = {br_q[31], br_q} - {bl_q[31], bl_q};
	assign wmag  = diff[32] ? 32'(-diff) : diff[31:0];
	assign sum   = {bl_q[31], bl_q} + {br_q[31], br_q};
	assign mid   = sum[32:1];  // floor of half the exact sum
	assign den   = {vr_q[31], vr_q} - {vl_q[31], vl_q};
	assign flmag = vl_q[31] ? 32'(-vl_q) : 32'(vl_q);

	// strictly opposite signs of f(left) and f(probe)
	assign move_right = (vl_q != '0) && (probe_value != '0) && (vl_q[31] ^ probe_value[31]);

	brf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num_q),
		.den    (dmag_q),
		.done   (div_done),
		.quo    (quo)
	);

	// x = left - sign*q, then clamp into the bracket
	assign q_ext = {2'b00, quo};
	assign x_raw = neg_q ? (66'(bl_q) + q_ext) : (66'(bl_q) - q_ext);
	assign lo    = (bl_q < br_q) ? bl_q : br_q;
	assign hi    = (bl_q < br_q) ? br_q : bl_q;

	always_comb begin
		if (x_raw < 66'(lo))
			x_clamp = lo;
		else if (x_raw > 66'(hi))
			x_clamp = hi;
		else
			x_clamp = x_raw[31:0];
	end

	always_comb begin
		case (cmd.psel)
			brf_pkg::PSEL_ZERO: pt = '0;
			brf_pkg::PSEL_CUR:  pt = cp_q;
			brf_pkg::PSEL_MID:  pt = mid;
			brf_pkg::PSEL_FP:   pt = fp_q;
			default:            pt = cp_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bl_q <= '0;
			br_q <= '0;
			vl_q <= '0;
			vr_q <= '0;
			cp_q <= '0;
			pd_q <= '0;
		end else begin
			if (cmd.start_load) begin
				bl_q <= left_end;
				br_q <= right_end;
				vl_q <= left_value;
				vr_q <= right_value;
				pd_q <= '0;
			end else if (cmd.value_update) begin
				if (pd_q != 16'hFFFF)
					pd_q <= pd_q + 1'b1;
				if (move_right) begin
					br_q <= cp_q;
					vr_q <= probe_value;
				end else begin
					bl_q <= cp_q;
					vl_q <= probe_value;
				end
			end
			if (cmd.out_load && (cmd.psel == brf_pkg::PSEL_MID || cmd.psel == brf_pkg::PSEL_FP))
				cp_q <= pt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_load) begin
			num_q  <= 64'(flmag) * 64'(wmag);
			dmag_q <= den[32] ? 33'(-den) : den;
			neg_q  <= vl_q[31] ^ diff[32] ^ den[32];
		end
		if (cmd.clamp_load)
			fp_q <= x_clamp;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.out_load) begin
			ov_q <= 1'b1;
		end else if (!out_stall) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			op_q <= pt;
			os_q <= 3'(cmd.status);
			oc_q <= pd_q;
		end
	end

	assign stat.sign_change = (vl_q != '0) && (vr_q != '0) && (vl_q[31] ^ vr_q[31]);
	assign stat.den_zero    = (vr_q == vl_q);
	assign stat.width_ok    = (wmag <= {1'b0, width_tolerance});
	assign stat.cap_hit     = (pd_q >= iteration_cap);
	assign stat.div_done    = div_done;
	assign stat.out_free    = ~ov_q | ~out_stall;

	assign out_valid   = ov_q;
	assign probe_point = op_q;
	assign status      = os_q;
	assign probe_count = oc_q;

endmodule

>>> rtl/brf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_ctrl: root finder controller
// Sequences start and value words through test, probe forming and output.
// ----------------------------------------------------------------------------
module brf_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    req_type,
	input  logic                    method_select,
	input  brf_pkg::dp_stat_t       stat,
	output brf_pkg::cmd_t           cmd
);

	brf_pkg::state_t  state_q, state_d;
	brf_pkg::status_t fin_status_q, fin_status_d;
	brf_pkg::psel_t   fin_psel_q, fin_psel_d;
	logic             active_q, active_d;
	logic             accept;

	assign in_stall = (state_q != brf_pkg::S_IDLE);
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= brf_pkg::S_IDLE;
			fin_status_q <= brf_pkg::STAT_PROBE;
			fin_psel_q   <= brf_pkg::PSEL_ZERO;
			active_q     <= 1'b0;
		end else begin
			state_q      <= state_d;
			fin_status_q <= fin_status_d;
			fin_psel_q   <= fin_psel_d;
			active_q     <= active_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		fin_status_d = fin_status_q;
		fin_psel_d   = fin_psel_q;
		active_d     = active_q;
		cmd          = '0;
		cmd.status   = fin_status_q;
		cmd.psel     = fin_psel_q;

		case (state_q)
			brf_pkg::S_IDLE: begin
				if (accept) begin
					if (req_type == brf_pkg::REQ_START) begin
						cmd.start_load = 1'b1;
						state_d        = brf_pkg::S_START;
					end else if (active_q) begin
						cmd.value_update = 1'b1;
						state_d          = brf_pkg::S_CHECK;
					end else begin
						fin_status_d = brf_pkg::STAT_IGNORED;
						fin_psel_d   = brf_pkg::PSEL_CUR;
						state_d      = brf_pkg::S_FINISH;
					end
				end
			end
			brf_pkg::S_START: begin
				if (!stat.sign_change) begin
					active_d     = 1'b0;
					fin_status_d = brf_pkg::STAT_NOSIGN;
					fin_psel_d   = brf_pkg::PSEL_ZERO;
					state_d      = brf_pkg::S_FINISH;
				end else begin
					state_d = brf_pkg::S_PROBE;
				end
			end
			brf_pkg::S_CHECK: begin
				if (stat.width_ok) begin
					active_d     = 1'b0;
					fin_status_d = brf_pkg::STAT_CONV;
					fin_psel_d   = brf_pkg::PSEL_CUR;
					state_d      = brf_pkg::S_FINISH;
				end else if (stat.cap_hit) begin
					active_d     = 1'b0;
					fin_status_d = brf_pkg::STAT_CAP;
					fin_psel_d   = brf_pkg::PSEL_CUR;
					state_d      = brf_pkg::S_FINISH;
				end else begin
					state_d = brf_pkg::S_PROBE;
				end
			end
			brf_pkg::S_PROBE: begin
				if (method_select == brf_pkg::METH_BISECT) begin
					active_d     = 1'b1;
					fin_status_d = brf_pkg::STAT_PROBE;
					fin_psel_d   = brf_pkg::PSEL_MID;
					state_d      = brf_pkg::S_FINISH;
				end else if (stat.den_zero) begin
					active_d     = 1'b0;
					fin_status_d = brf_pkg::STAT_DENZERO;
					fin_psel_d   = brf_pkg::PSEL_CUR;
					state_d      = brf_pkg::S_FINISH;
				end else begin
					cmd.mul_load = 1'b1;
					state_d      = brf_pkg::S_MUL;
				end
			end
			brf_pkg::S_MUL: begin
				cmd.div_start = 1'b1;
				state_d       = brf_pkg::S_DIV;
			end
			brf_pkg::S_DIV: begin
				if (stat.div_done)
					state_d = brf_pkg::S_CLAMP;
			end
			brf_pkg::S_CLAMP: begin
				cmd.clamp_load = 1'b1;
				active_d       = 1'b1;
				fin_status_d   = brf_pkg::STAT_PROBE;
				fin_psel_d     = brf_pkg::PSEL_FP;
				state_d        = brf_pkg::S_FINISH;
			end
			brf_pkg::S_FINISH: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = brf_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = brf_pkg::S_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/bracketing_root_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracketing_root_finder: bisection / false-position root finder, Q16.16
// An ignored word goes straight to the output register; no sign change,
// converged or cap take a test state first, a bisection probe or a zero
// denominator a test and a probe state, and a false-position probe also the
// bit-serial divider. One word in flight: the next word is taken once the
// output register is loaded, and the load waits while a full output register is stalled.
// Reset clears the search state to idle and loads the register defaults.
// ----------------------------------------------------------------------------
module bracketing_root_finder (
	input  logic               clk,
	input  logic               arst_n,

	// configuration write port
	input  logic                            cfg_write_en,
	input  logic [brf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [30:0]                     cfg_data,

	// input words
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic signed [31:0] left_end,
	input  logic signed [31:0] right_end,
	input  logic signed [31:0] left_value,
	input  logic signed [31:0] right_value,
	input  logic signed [31:0] probe_value,

	// result words
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] probe_point,
	output logic [2:0]         status,
	output logic [15:0]        probe_count
);

	// configuration registers; the user must write them only while the block is idle, the block does not enforce it
	logic        method_q;
	logic [30:0] tol_q;
	logic [15:0] cap_q;

	brf_pkg::cmd_t     cmd;
	brf_pkg::dp_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= brf_pkg::METH_BISECT;
			tol_q    <= brf_pkg::TOL_RESET;
			cap_q    <= brf_pkg::CAP_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				brf_pkg::CFG_METHOD: method_q <= cfg_data[0];
				brf_pkg::CFG_TOL:    tol_q    <= cfg_data;
				brf_pkg::CFG_CAP:    cap_q    <= cfg_data[15:0];
				default: ;  // unmapped index: write dropped
			endcase
		end
	end

	// controller: one word at a time, stall while a word is being worked
	brf_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.method_select (method_q),
		.stat          (stat),
		.cmd           (cmd)
	);

	// datapath: bracket, tests, midpoint/secant, output register
	brf_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.left_end        (left_end),
		.right_end       (right_end),
		.left_value      (left_value),
		.right_value     (right_value),
		.probe_value     (probe_value),
		.width_tolerance (tol_q),
		.iteration_cap   (cap_q),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.probe_point     (probe_point),
		.status          (status),
		.probe_count     (probe_count)
	);

endmodule

>>> dv/bracketing_root_finder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracketing_root_finder_tb: self-checking bench for the bracketing root finder
// Stands in for the external function evaluator. It starts searches, answers
// each probe with f(probe) from a simple function model, and checks every
// result word against an in-bench model of the bracket/probe arithmetic.
// Directed cases cover the corners; random phases sweep method, tolerance, cap.
// ----------------------------------------------------------------------------
module bracketing_root_finder_tb;

	localparam int QUIET_LIMIT  = 1000;  // cycles without any handshake
	localparam int TAIL_CYCLES  = 100;   // settle time after the last result
	localparam int Q_ONE        = 1 << brf_pkg::FRAC_BITS;
	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
	localparam longint L_MAX = 64'sd2147483647;
	localparam longint L_MIN = -64'sd2147483648;

	// shape of the function the bench evaluates for the block
	typedef enum int {SHAPE_LINEAR, SHAPE_STEP, SHAPE_NOISE} shape_t;

	typedef struct packed {
		logic signed [31:0] point;
		brf_pkg::status_t   code;
		logic [15:0]        count;
	} result_word_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                          cfg_write_en = 1'b0;
	logic [brf_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
	logic [30:0]                   cfg_data     = '0;

	logic               in_valid    = 1'b0;
	logic               in_stall;
	logic               req_type    = brf_pkg::REQ_START;
	logic signed [31:0] left_end    = '0;
	logic signed [31:0] right_end   = '0;
	logic signed [31:0] left_value  = '0;
	logic signed [31:0] right_value = '0;
	logic signed [31:0] probe_value = '0;

	logic               out_valid;
	logic               out_stall   = 1'b0;
	logic signed [31:0] probe_point;
	logic [2:0]         status;
	logic [15:0]        probe_count;

	// bench model of the block: register copies and search state
	logic               sel_method  = brf_pkg::METH_BISECT;
	logic [30:0]        tol_width   = brf_pkg::TOL_RESET;
	logic [15:0]        probe_cap   = brf_pkg::CAP_RESET;
	logic signed [31:0] br_left     = '0;
	logic signed [31:0] br_right    = '0;
	logic signed [31:0] fv_left     = '0;
	logic signed [31:0] fv_right    = '0;
	logic signed [31:0] cur_point   = '0;
	logic [15:0]        probes_seen = '0;
	bit                 searching   = 1'b0;

	result_word_t predicted_words[$];
	int           error_count = 0;

	// idling switches for the two channels
	bit in_idle_on  = 1'b1;
	bit out_idle_on = 1'b1;

	// function being searched
	longint      fn_root  = 0;
	shape_t      fn_shape = SHAPE_LINEAR;
	int          fn_shift = 0;
	int unsigned fn_mag   = 0;
	bit          fn_flip  = 1'b0;

	bracketing_root_finder uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.left_end    (left_end),
		.right_end   (right_end),
		.left_value  (left_value),
		.right_value (right_value),
		.probe_value (probe_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.probe_point (probe_point),
		.status      (status),
		.probe_count (probe_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// model of the block
	// ------------------------------------------------------------------

	function automatic int sign_of(logic signed [31:0] v);
		return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
	endfunction

	// next probe from the current bracket; 0 means the secant denominator is zero
	function automatic bit form_probe(output logic signed [31:0] point);
		logic signed [32:0] sum;
		logic signed [32:0] den;
		logic signed [32:0] span;
		logic signed [79:0] quo;
		logic signed [79:0] x;
		logic signed [79:0] lo;
		logic signed [79:0] hi;
		point = cur_point;
		if (sel_method == brf_pkg::METH_BISECT) begin
			// floor of the exact 33-bit sum over two
			sum = 33'(br_left) + 33'(br_right);
			sum = sum >>> 1;
			point = sum[31:0];
			return 1'b1;
		end
		den = 33'(fv_right) - 33'(fv_left);
		if (den == 0)
			return 1'b0;
		span = 33'(br_right) - 33'(br_left);
		// exact product, quotient truncated toward zero
		quo = (80'(fv_left) * 80'(span)) / 80'(den);
		x = 80'(br_left) - quo;
		lo = (br_left < br_right) ? 80'(br_left) : 80'(br_right);
		hi = (br_left < br_right) ? 80'(br_right) : 80'(br_left);
		if (x < lo)
			x = lo;
		if (x > hi)
			x = hi;
		point = x[31:0];
		return 1'b1;
	endfunction

	// apply one accepted word to the model and queue the result it must produce
	function automatic void advance_search(logic rt, logic signed [31:0] le,
		logic signed [31:0] re, logic signed [31:0] lv, logic signed [31:0] rv,
		logic signed [31:0] pv);
		result_word_t       want;
		logic signed [31:0] pt;
		logic signed [32:0] width;
		pt = '0;
		if (rt == brf_pkg::REQ_START) begin
			br_left = le;
			br_right = re;
			fv_left = lv;
			fv_right = rv;
			probes_seen = '0;
			if (sign_of(lv) * sign_of(rv) >= 0) begin
				// zero at an end or same sign: nothing to bracket
				searching = 1'b0;
				want.code = brf_pkg::STAT_NOSIGN;
				pt = '0;
			end else if (!form_probe(pt)) begin
				searching = 1'b0;
				want.code = brf_pkg::STAT_DENZERO;
				pt = cur_point;
			end else begin
				cur_point = pt;
				searching = 1'b1;
				want.code = brf_pkg::STAT_PROBE;
			end
		end else if (!searching) begin
			want.code = brf_pkg::STAT_IGNORED;
			pt = cur_point;
		end else begin
			if (probes_seen != 16'hFFFF)
				probes_seen = probes_seen + 16'd1;
			// strictly opposite signs move the right end, anything else the left
			if (sign_of(fv_left) * sign_of(pv) < 0) begin
				br_right = cur_point;
				fv_right = pv;
			end else begin
				br_left = cur_point;
				fv_left = pv;
			end
			width = 33'(br_right) - 33'(br_left);
			if (width < 0)
				width = -width;
			// width test wins over the cap, cap over forming the next probe
			if (width <= $signed({2'b00, tol_width})) begin
				searching = 1'b0;
				want.code = brf_pkg::STAT_CONV;
				pt = cur_point;
			end else if (probes_seen >= probe_cap) begin
				searching = 1'b0;
				want.code = brf_pkg::STAT_CAP;
				pt = cur_point;
			end else if (!form_probe(pt)) begin
				searching = 1'b0;
				want.code = brf_pkg::STAT_DENZERO;
				pt = cur_point;
			end else begin
				cur_point = pt;
				want.code = brf_pkg::STAT_PROBE;
			end
		end
		want.point = pt;
		want.count = probes_seen;
		predicted_words.push_back(want);
	endfunction

	// ------------------------------------------------------------------
	// function model: what the outside evaluator answers at x
	// ------------------------------------------------------------------

	function automatic logic signed [31:0] fn_value(logic signed [31:0] x);
		longint d;
		longint v;
		d = longint'(x) - fn_root;
		case (fn_shape)
			SHAPE_LINEAR: begin
				v = d >>> fn_shift;
			end
			SHAPE_STEP: begin
				// sign of (x - root) with a random size
				v = 1 + longint'($urandom_range(0, fn_mag));
				if (d < 0)
					v = -v;
				else if (d == 0)
					v = 0;
			end
			default: begin
				v = longint'($signed($urandom));
			end
		endcase
		if (fn_flip)
			v = -v;
		if (v > L_MAX)
			v = L_MAX;
		if (v < L_MIN)
			v = L_MIN;
		return v[31:0];
	endfunction

	// ------------------------------------------------------------------
	// input side
	// ------------------------------------------------------------------

	// one word onto the input channel; returns at the edge it is taken
	task automatic send_word(logic rt, logic signed [31:0] le, logic signed [31:0] re,
		logic signed [31:0] lv, logic signed [31:0] rv, logic signed [31:0] pv);
		int gap;
		gap = in_idle_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= rt;
		left_end    <= le;
		right_end   <= re;
		left_value  <= lv;
		right_value <= rv;
		probe_value <= pv;
		do @(posedge clk); while (in_stall !== 1'b0);
		advance_search(rt, le, re, lv, rv, pv);
	endtask

	// fields a word does not use carry random bits
	task automatic send_start(logic signed [31:0] le, logic signed [31:0] re,
		logic signed [31:0] lv, logic signed [31:0] rv);
		send_word(brf_pkg::REQ_START, le, re, lv, rv, $urandom);
	endtask

	task automatic send_value(logic signed [31:0] pv);
		send_word(brf_pkg::REQ_VALUE, $urandom, $urandom, $urandom, $urandom, pv);
	endtask

	// hold off until every predicted word is back; always spends at least one edge
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (predicted_words.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// registers change only with the block idle
	task automatic set_config(logic meth, logic [30:0] tol, logic [15:0] cap);
		wait_drained();
		cfg_write_en <= 1'b1;
		cfg_index    <= brf_pkg::CFG_METHOD;
		cfg_data     <= 31'(meth);
		@(posedge clk);
		cfg_index    <= brf_pkg::CFG_TOL;
		cfg_data     <= tol;
		@(posedge clk);
		cfg_index    <= brf_pkg::CFG_CAP;
		cfg_data     <= 31'(cap);
		@(posedge clk);
		cfg_write_en <= 1'b0;
		sel_method = meth;
		tol_width  = tol;
		probe_cap  = cap;
	endtask

	// new bracket around a random root; now and then a start with random values
	task automatic start_search();
		logic signed [31:0] le;
		logic signed [31:0] re;
		longint lo;
		longint hi;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 35) begin
			le = $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
			re = $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
		end else begin
			le = $urandom;
			re = $urandom;
		end
		lo = (le < re) ? longint'(le) : longint'(re);
		hi = (le < re) ? longint'(re) : longint'(le);
		fn_root  = lo + longint'($urandom_range(0, 32'(hi - lo)));
		fn_flip  = 1'($urandom_range(0, 1));
		fn_shift = $urandom_range(0, 16);
		fn_mag   = (1 << $urandom_range(0, 30)) - 1;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			fn_shape = SHAPE_LINEAR;
		else if (roll < 85)
			fn_shape = SHAPE_STEP;
		else
			fn_shape = SHAPE_NOISE;
		if ($urandom_range(0, 9) == 0)
			send_start(le, re, $urandom, $urandom);
		else
			send_start(le, re, fn_value(le), fn_value(re));
	endtask

	// mostly complete searches; a few stray words and restarts in mid-search
	task automatic run_searches(int goal);
		int done_items;
		int steps_left;
		int roll;
		done_items = 0;
		steps_left = 0;
		while (done_items < goal) begin
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				// random value: noise mid-search, ignored while idle
				if (searching)
					done_items++;
				send_value($urandom);
			end else if (!searching || steps_left == 0) begin
				start_search();
				steps_left = $urandom_range(3, 60);
				done_items++;
			end else begin
				send_value(fn_value(cur_point));
				steps_left--;
				done_items++;
			end
			if (roll == 99)
				wait_drained();
		end
	endtask

	// ------------------------------------------------------------------
	// output side
	// ------------------------------------------------------------------

	task automatic report_mismatch(string what, logic signed [63:0] got,
		logic signed [63:0] want);
		$display("ERROR %s: got %0d, expected %0d at %0t", what, got, want, $time);
		error_count++;
	endtask

	task automatic check_result();
		result_word_t want;
		if (predicted_words.size() == 0) begin
			report_mismatch("result word with none pending", 64'(probe_point), 64'(0));
			return;
		end
		want = predicted_words.pop_front();
		if (probe_point !== want.point)
			report_mismatch("probe_point", 64'(probe_point), 64'(want.point));
		if (status !== want.code)
			report_mismatch("status", 64'(status), 64'(want.code));
		if (probe_count !== want.count)
			report_mismatch("probe_count", 64'(probe_count), 64'(want.count));
	endtask

	// receiver: random stall before each word, then take it
	initial begin : result_sink
		int hold;
		forever begin
			hold = out_idle_on ? $urandom_range(0, 4) : 0;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (out_valid !== 1'b1);
			check_result();
		end
	end

	// ends a hung run: no word moved on either channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid === 1'b1 && in_stall === 1'b0)
				|| (out_valid === 1'b1 && out_stall === 1'b0))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// a value word straight out of reset has no search to join
	task automatic test_idle_value_ignored();
		send_value(Q_MAX);
	endtask

	// zero at either end or equal signs end the search at once
	task automatic test_no_sign_change();
		send_start(Q_MIN, Q_MAX, 0, 5);
		send_start(Q_MIN, Q_MAX, Q_MAX, 1);
		send_start(Q_MAX, Q_MIN, Q_MIN, -1);
		send_start(-Q_ONE, Q_ONE, -3, 0);
		send_value(Q_MIN);
	endtask

	// widest bracket, extreme and zero function values
	task automatic test_bisection_extremes();
		set_config(brf_pkg::METH_BISECT, brf_pkg::TOL_RESET, brf_pkg::CAP_RESET);
		send_start(Q_MIN, Q_MAX, Q_MIN, Q_MAX);
		send_value(Q_MAX);
		send_value(Q_MIN);
		send_value(0);
		send_value(-1);
		// reversed bracket
		send_start(Q_MAX, Q_MIN, 1, -1);
	endtask

	// secant point, clamp to the bracket, and a zero denominator
	task automatic test_false_position();
		set_config(brf_pkg::METH_FALSEPOS, brf_pkg::TOL_RESET, brf_pkg::CAP_RESET);
		send_start(-5 * Q_ONE, 7 * Q_ONE, -5 * Q_ONE, 7 * Q_ONE);
		// f = 0 moves the left end and zeroes f(left)
		send_value(0);
		// f(left) now equals f(right): denominator is zero
		send_value(7 * Q_ONE);
		// huge quotient, must clamp
		send_start(Q_MIN, Q_MAX, Q_MIN, 1);
		send_value(Q_MAX);
	endtask

	// tolerance and cap at their extremes, including a cap of zero
	task automatic test_stop_conditions();
		set_config(brf_pkg::METH_BISECT, 31'h7FFF_FFFF, brf_pkg::CAP_RESET);
		send_start(-Q_ONE, Q_ONE, -1, 1);
		send_value(5);
		set_config(brf_pkg::METH_BISECT, '0, 16'd1);
		send_start(-Q_ONE, Q_ONE, -1, 1);
		send_value(5);
		set_config(brf_pkg::METH_FALSEPOS, '0, 16'd0);
		send_start(-3 * Q_ONE, Q_ONE, -2, 9);
		send_value(-4);
	endtask

	// a start word in mid-search drops the old search
	task automatic test_restart();
		set_config(brf_pkg::METH_BISECT, brf_pkg::TOL_RESET, 16'hFFFF);
		send_start(-8 * Q_ONE, 8 * Q_ONE, 16, -16);
		send_value(4);
		send_start(Q_ONE, 9 * Q_ONE, -1, 1);
		send_value(1);
	endtask

	// random searches over several register settings and idling mixes
	task automatic test_random_searches();
		int phase;
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_config(brf_pkg::METH_BISECT, brf_pkg::TOL_RESET, brf_pkg::CAP_RESET);
				1: set_config(brf_pkg::METH_FALSEPOS, brf_pkg::TOL_RESET, brf_pkg::CAP_RESET);
				2: set_config(brf_pkg::METH_BISECT, '0, 16'hFFFF);
				3: set_config(brf_pkg::METH_FALSEPOS, 31'($urandom_range(0, 32'hF_FFFF)),
					16'($urandom_range(1, 40)));
				4: set_config(brf_pkg::METH_FALSEPOS, '0, 16'hFFFF);
				default: set_config(brf_pkg::METH_BISECT,
					31'($urandom >> $urandom_range(1, 31)), 16'($urandom_range(0, 24)));
			endcase
			// phase 1 runs with no idling at all
			in_idle_on  = (phase != 1) && (phase != 3);
			out_idle_on = (phase != 1) && (phase != 2);
			run_searches(155);
		end
		in_idle_on  = 1'b1;
		out_idle_on = 1'b1;
	endtask

	initial begin : test_sequence
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_value_ignored();
		test_no_sign_change();
		test_bisection_extremes();
		test_false_position();
		test_stop_conditions();
		test_restart();
		test_random_searches();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> sim.f
rtl/brf_pkg.sv
rtl/brf_div.sv
rtl/brf_dp.sv
rtl/brf_ctrl.sv
rtl/bracketing_root_finder.sv
dv/bracketing_root_finder_tb.sv
